[hw/rtl/dbel_pkg.sv]
// Package with the shared types, codes and sizes of the debounced button edge latch.
`timescale 1ns / 1ps

package dbel_pkg;

  // Field widths of the input and result beats
  localparam int ACT_W  = 3;
  localparam int BTN_W  = 32;
  localparam int IDX_W  = 5;
  localparam int PIN_W  = 5;
  localparam int THR_W  = 16;
  localparam int CNT_W  = 16;

  // Logical to physical pin table
  localparam int MAP_DEPTH = 32;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // Stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W  = BTN_W + IDX_W + PIN_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = 8;
  localparam int OUT_FIELDS_W = 2 + BTN_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Threshold value after reset
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

  // Action codes as they arrive on the input stream
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SAMPLE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FELL    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ROSE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PRESSED = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MAP     = 3'd5;

  // Operations after classification
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SAMPLE,
    OP_FELL,
    OP_ROSE,
    OP_PRESSED,
    OP_MAP,
    OP_NONE
  } op_t;

  // One classified item as it travels through the queue
  typedef struct packed {
    op_t              op;
    logic             idx_ok;
    logic [IDX_W-1:0] idx;
    logic [PIN_W-1:0] pin;
    logic [BTN_W-1:0] raw;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [BTN_W-1:0] state;
    logic             taken;
    logic             answer;
  } res_t;

endpackage

[hw/rtl/dbel_front.sv]
// Front end: unpacks an input beat and classifies it into an operation.
`timescale 1ns / 1ps

module dbel_front
  import dbel_pkg::*;
(
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  output item_t                 item
);

  logic [ACT_W-1:0] action;

  assign action = in_tuser[ACT_W-1:0];

  // Field unpacking, index range check and action decode; unused codes become a no-operation
  always_comb begin
    item.raw    = in_tdata[BTN_W-1:0];
    item.idx    = in_tdata[BTN_W +: IDX_W];
    item.pin    = in_tdata[BTN_W+IDX_W +: PIN_W];
    item.idx_ok = (32'(item.idx) < MAP_DEPTH);
    case (action)
      ACT_TICK:    item.op = OP_TICK;
      ACT_SAMPLE:  item.op = OP_SAMPLE;
      ACT_FELL:    item.op = OP_FELL;
      ACT_ROSE:    item.op = OP_ROSE;
      ACT_PRESSED: item.op = OP_PRESSED;
      ACT_MAP:     item.op = OP_MAP;
      default:     item.op = OP_NONE;
    endcase
  end

endmodule

[hw/rtl/dbel_queue.sv]
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module dbel_queue
  import dbel_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  item_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]    count_r, count_nxt;

  assign full      = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hw/rtl/dbel_back.sv]
// Back end: debounce state, edge latches, pin table and the result register.
`timescale 1ns / 1ps

module dbel_back
  import dbel_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [THR_W-1:0] threshold,
  input  logic             item_valid,
  input  item_t            item,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  logic [BTN_W-1:0] pressed_r, pressed_nxt;
  logic [BTN_W-1:0] fell_r, fell_nxt;
  logic [BTN_W-1:0] rose_r, rose_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PIN_W-1:0] map_r [MAP_DEPTH];
  logic             res_valid_r, res_valid_nxt;
  res_t             res_r, res_nxt;

  logic [PIN_W-1:0] pin_sel;
  logic [BTN_W-1:0] mask;
  logic [BTN_W-1:0] now_bits;
  logic             map_we;

  // Take an item whenever the result register is free or being drained
  assign pop       = item_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign pin_sel  = item.idx_ok ? map_r[item.idx[MAP_AW-1:0]] : '0;
  assign mask     = BTN_W'(1) << pin_sel;
  assign now_bits = ~item.raw;
  assign map_we   = pop && (item.op == OP_MAP) && item.idx_ok;

  // Execute the operation at the head of the queue
  always_comb begin
    pressed_nxt    = pressed_r;
    fell_nxt       = fell_r;
    rose_nxt       = rose_r;
    count_nxt      = count_r;
    res_nxt.answer = 1'b0;
    res_nxt.taken  = 1'b0;
    case (item.op)
      OP_TICK: begin
        if (count_r != '1) begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_SAMPLE: begin
        if (count_r > threshold) begin
          pressed_nxt   = now_bits;
          fell_nxt      = fell_r | (now_bits & ~pressed_r);
          rose_nxt      = rose_r | (~now_bits & pressed_r);
          res_nxt.taken = 1'b1;
          if (now_bits != pressed_r) begin
            count_nxt = '0;
          end
        end
      end
      OP_FELL: begin
        if (item.idx_ok && ((fell_r & mask) != '0)) begin
          fell_nxt       = fell_r & ~mask;
          res_nxt.answer = 1'b1;
        end
      end
      OP_ROSE: begin
        if (item.idx_ok && ((rose_r & mask) != '0)) begin
          rose_nxt       = rose_r & ~mask;
          res_nxt.answer = 1'b1;
        end
      end
      OP_PRESSED: begin
        res_nxt.answer = item.idx_ok && ((pressed_r & mask) != '0);
      end
      default: begin
      end
    endcase
    res_nxt.state = pressed_nxt;
  end

  // Result register handshake
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (pop) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r   <= '0;
      fell_r      <= '0;
      rose_r      <= '0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (pop) begin
        pressed_r <= pressed_nxt;
        fell_r    <= fell_nxt;
        rose_r    <= rose_nxt;
        count_r   <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  // Pin table, cleared to zero by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_DEPTH; i++) begin
        map_r[i] <= '0;
      end
    end else if (map_we) begin
      map_r[item.idx[MAP_AW-1:0]] <= item.pin;
    end
  end

endmodule

[hw/rtl/debounced_button_edge_latch_top.sv]
// Top level of the debounced button scanner with sticky edge latches.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   in_      | slave     | in_tvalid/in_tready   | tdata raw/index/pin, tuser action
//   out_     | master    | out_tvalid/out_tready | tdata answer/sample_taken/state
//   cfg_     | slave     | cfg_valid/cfg_ready   | cfg_data debounce threshold
//
// One beat per clock is sustained in both directions while out_tready is high; each
// input beat passes the queue and the result register to give one result beat. The
// back end executes one operation per cycle while the result register is free or
// being drained, reading the pin table once. Synchronous reset clears the state,
// the latches and the pin table. While out_tready is low the result holds and the
// queue fills, after which in_tready drops. The configuration port is always ready.
`timescale 1ns / 1ps

module debounced_button_edge_latch_top
  import dbel_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // raw_pins[31:0], map_index[36:32],
                                             // pin_number[41:37], zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // action[2:0], zero pad
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // answer[0], sample_taken[1],
                                             // button_state[33:2], zero pad
  // Configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [THR_W-1:0]       cfg_data
);

  logic [THR_W-1:0] threshold_r;
  item_t            front_item;
  item_t            head_item;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  res_t             res;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res};

  // Debounce threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_data;
    end
  end

  dbel_front u_front (
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .item     (front_item)
  );

  dbel_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (head_item)
  );

  dbel_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .threshold  (threshold_r),
    .item_valid (q_not_empty),
    .item       (head_item),
    .pop        (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

endmodule

[hw/rtl/dbel_checker.sv]
// Port-level checks of the debounced button edge latch, bound to the top level.
`timescale 1ns / 1ps

module dbel_checker
  import dbel_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A result beat held back stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A result beat held back keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // A query answer and an accepted sample never share a beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("answer and sample_taken both set");

  // Reset leaves no result pending
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // The input side only backs up behind a pending result
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind debounced_button_edge_latch_top dbel_checker u_dbel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
